FILE: rtl/core/cpr_pkg.sv
// Package for the checksummed packet receiver: character codes, result kinds,
// the result struct shared by the framer and the top level, and the hex digit decode.
// No dependencies.
package cpr_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_BREAK  = 8'h03;
  localparam logic [7:0] CH_ACK    = 8'h2B;
  localparam logic [7:0] CH_NACK   = 8'h2D;

  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_GOOD     = 2'd1;
  localparam logic [1:0] KIND_BAD      = 2'd2;
  localparam logic [1:0] KIND_BREAK_RQ = 2'd3;

  localparam int unsigned LEN_W  = 16;
  localparam int unsigned RSUM_W = 13;

  typedef struct packed {
    logic              vld;
    logic [1:0]        kind;
    logic [7:0]        data_byte;
    logic [LEN_W-1:0]  payload_length;
    logic [7:0]        computed_sum;
    logic [RSUM_W-1:0] received_sum;
  } cpr_result_t;

  // Hex digit value; a character that is not a hex digit keeps its raw code.
  function automatic logic [7:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = c;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end
    return v;
  endfunction

endpackage

FILE: rtl/core/cpr_framer.sv
// Packet framer: phase machine, running sum, length count and checksum check.
// Depends on cpr_pkg.
module cpr_framer #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           rx_byte,
  output cpr_pkg::cpr_result_t result
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HASH,
    PH_CK1,
    PH_CK2
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [7:0]             sum_r, sum_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [7:0]             first_r, first_nxt;
  logic [cpr_pkg::LEN_W-1:0]  len_sat;
  logic [cpr_pkg::RSUM_W-1:0] rsum;
  logic [7:0]             sum_add;

  // Length as reported: the count clipped to the 16-bit field.
  generate
    if (COUNT_WIDTH > cpr_pkg::LEN_W) begin : g_wide
      assign len_sat = (|cnt_r[COUNT_WIDTH-1:cpr_pkg::LEN_W]) ? '1
                                                               : cnt_r[cpr_pkg::LEN_W-1:0];
    end else if (COUNT_WIDTH == cpr_pkg::LEN_W) begin : g_same
      assign len_sat = cnt_r;
    end else begin : g_narrow
      assign len_sat = {{(cpr_pkg::LEN_W-COUNT_WIDTH){1'b0}}, cnt_r};
    end
  endgenerate

  assign rsum = {1'b0, cpr_pkg::hex_value(first_r), 4'b0000}
              + {5'b00000, cpr_pkg::hex_value(rx_byte)};
  assign sum_add = sum_r + rx_byte;

  always_comb begin
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    first_nxt = first_r;
    result    = '0;
    unique case (phase_r)
      PH_IDLE: begin
        if (rx_byte == cpr_pkg::CH_DOLLAR) begin
          phase_nxt = PH_HASH;
          sum_nxt   = '0;
          cnt_nxt   = '0;
        end else if (rx_byte == cpr_pkg::CH_BREAK) begin
          result.vld       = 1'b1;
          result.kind      = cpr_pkg::KIND_BREAK_RQ;
          result.data_byte = cpr_pkg::CH_ACK;
        end
      end
      PH_HASH: begin
        if (rx_byte == cpr_pkg::CH_HASH) begin
          phase_nxt = PH_CK1;
        end else begin
          sum_nxt = sum_add;
          if (cnt_r != '1) begin
            cnt_nxt = cnt_r + 1'b1;
          end
          result.vld       = 1'b1;
          result.kind      = cpr_pkg::KIND_PAYLOAD;
          result.data_byte = rx_byte;
        end
      end
      PH_CK1: begin
        first_nxt = rx_byte;
        phase_nxt = PH_CK2;
      end
      PH_CK2: begin
        phase_nxt             = PH_IDLE;
        result.vld            = 1'b1;
        result.payload_length = len_sat;
        result.computed_sum   = sum_r;
        result.received_sum   = rsum;
        if (rsum == {5'b00000, sum_r}) begin
          result.kind      = cpr_pkg::KIND_GOOD;
          result.data_byte = cpr_pkg::CH_ACK;
        end else begin
          result.kind      = cpr_pkg::KIND_BAD;
          result.data_byte = cpr_pkg::CH_NACK;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
    if (!step) begin
      result.vld = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      sum_r   <= '0;
      cnt_r   <= '0;
      first_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      cnt_r   <= cnt_nxt;
      first_r <= first_nxt;
    end
  end

endmodule

FILE: rtl/core/checksummed_packet_receiver_top.sv
// Top level of the checksummed packet receiver: input word register, framer
// and output result register. Depends on cpr_pkg and cpr_framer.
//
//   Channel | Direction | Handshake           | Payload
//   in_     | input     | in_valid / in_stall | in_rx_byte
//   out_    | output    | out_valid/out_stall | out_kind, out_data_byte, out_payload_length,
//           |           |                     | out_computed_sum, out_received_sum
//
// One word is taken every cycle unless the input stalls. A word waits in the input
// register, then the framer updates its state and any result lands in the output register.
// The rate is set by the single framer step between the two registers.
// Reset (synchronous, rst_n low) empties both registers and returns the framer to
// idle with a zero sum and count. A stalled output holds the framer and the input
// register; the input stalls only while the input register is full and cannot move.
module checksummed_packet_receiver_top #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic [15:0] out_payload_length,
  output logic [7:0]  out_computed_sum,
  output logic [12:0] out_received_sum
);

  logic                 in_vld_r;
  logic [7:0]           in_byte_r;
  logic                 adv;
  logic                 step;
  cpr_pkg::cpr_result_t res;
  cpr_pkg::cpr_result_t out_r;

  // The pipeline moves when the output register is empty or being drained.
  assign adv      = !out_r.vld || !out_stall;
  assign step     = in_vld_r && adv;
  assign in_stall = in_vld_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  // The byte register carries payload only, so it needs no reset.
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte_r <= in_rx_byte;
    end
  end

  cpr_framer #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_framer (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (in_byte_r),
    .result  (res)
  );

  // Result register. When the pipeline advances, a word that makes no result
  // simply leaves it empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r <= '0;
    end else if (adv) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_r.vld;
  assign out_kind           = out_r.kind;
  assign out_data_byte      = out_r.data_byte;
  assign out_payload_length = out_r.payload_length;
  assign out_computed_sum   = out_r.computed_sum;
  assign out_received_sum   = out_r.received_sum;

  // A good packet always carries matching sums.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == cpr_pkg::KIND_GOOD |->
      out_received_sum == {5'b00000, out_computed_sum} && out_data_byte == cpr_pkg::CH_ACK)
    else $error("good packet without matching checksum");

  // A bad packet is always answered with a nack.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == cpr_pkg::KIND_BAD |->
      out_data_byte == cpr_pkg::CH_NACK && out_received_sum != {5'b00000, out_computed_sum})
    else $error("bad packet result inconsistent");

  // Payload and break results carry no packet summary.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == cpr_pkg::KIND_PAYLOAD || out_kind == cpr_pkg::KIND_BREAK_RQ) |->
      out_payload_length == '0 && out_computed_sum == '0 && out_received_sum == '0)
    else $error("summary fields set on a non-packet result");

  // A word held back by the output keeps its place in the input register.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !adv |=> in_vld_r && $stable(in_byte_r))
    else $error("input word lost while the output was stalled");

  // The framer never steps while the output register is full and stalled.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> !step)
    else $error("framer stepped into a stalled output");

endmodule

FILE: sim/tb_checksummed_packet_receiver_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for checksummed_packet_receiver_top: a directed probe table, then
// random packets and line noise under several idle and stall mixes, checked by a predictor.
// Depends on cpr_pkg and the receiver RTL.
module tb_checksummed_packet_receiver_top;

  localparam int COUNT_W      = 16;
  localparam int RANDOM_WORDS = 1950;
  // One packet well past 255 bytes, so the length field uses its upper byte.
  localparam int LONG_PAYLOAD = 300;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int PROBE_ROWS   = 24;

  // Framer phases as the predictor tracks them.
  typedef enum logic [1:0] {
    RX_IDLE,
    RX_PAYLOAD,
    RX_SUM_HI,
    RX_SUM_LO
  } rx_phase_t;

  // One row of the directed table. When typed is set, want is the result the word must
  // cause (vld low means none); otherwise the predictor supplies the expectation.
  typedef struct {
    logic [7:0]           rx;
    bit                   typed;
    cpr_pkg::cpr_result_t want;
  } probe_row_t;

  localparam cpr_pkg::cpr_result_t NO_EVENT = '0;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_data_byte;
  logic [15:0] out_payload_length;
  logic [7:0]  out_computed_sum;
  logic [12:0] out_received_sum;

  // Predictor state, a private copy of what the framer holds.
  rx_phase_t            trk_phase;
  logic [7:0]           trk_sum;
  logic [COUNT_W-1:0]   trk_count;
  logic [7:0]           trk_first;

  // Results predicted for accepted words, oldest first.
  cpr_pkg::cpr_result_t frame_events[$];

  probe_row_t probe_rows[PROBE_ROWS];

  int  mismatches = 0;
  int  cycle_count = 0;
  int  words_sent = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  // Set by the stimulus to ask the receiver for one long hold-off; cleared by the receiver.
  bit  hold_req = 1'b0;
  int  hold_left = 0;

  checksummed_packet_receiver_top #(
    .COUNT_WIDTH(COUNT_W)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_data_byte     (out_data_byte),
    .out_payload_length(out_payload_length),
    .out_computed_sum  (out_computed_sum),
    .out_received_sum  (out_received_sum)
  );

  always #2 clk = ~clk;

  function automatic cpr_pkg::cpr_result_t mk_event(input logic [1:0] kind,
                                                    input logic [7:0] data,
                                                    input logic [15:0] len,
                                                    input logic [7:0] csum,
                                                    input logic [12:0] rsum);
    cpr_pkg::cpr_result_t ev;
    ev.vld            = 1'b1;
    ev.kind           = kind;
    ev.data_byte      = data;
    ev.payload_length = len;
    ev.computed_sum   = csum;
    ev.received_sum   = rsum;
    return ev;
  endfunction

  // Value of one checksum character. Anything that is not a hex digit counts with its
  // raw character code, which is how a checksum above 255 can come about.
  function automatic logic [12:0] checksum_digit(input logic [7:0] c);
    logic [12:0] v;
    v = {5'd0, c};
    if (c >= "0" && c <= "9") begin
      v = 13'(c - "0");
    end else if (c >= "a" && c <= "f") begin
      v = 13'(c - "a") + 13'd10;
    end else if (c >= "A" && c <= "F") begin
      v = 13'(c - "A") + 13'd10;
    end
    return v;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
    if (nib < 4'd10) begin
      return 8'("0") + 8'(nib);
    end
    return (upper ? 8'("A") : 8'("a")) + 8'(nib) - 8'd10;
  endfunction

  // Advances the predicted framer by one received character and returns the result that
  // character causes, with vld low when it causes none.
  function automatic cpr_pkg::cpr_result_t track_frame(input logic [7:0] ch);
    cpr_pkg::cpr_result_t ev;
    logic [12:0] rsum;
    logic [15:0] len;
    ev = NO_EVENT;
    case (trk_phase)
      RX_IDLE: begin
        if (ch == cpr_pkg::CH_DOLLAR) begin
          trk_phase = RX_PAYLOAD;
          trk_sum   = '0;
          trk_count = '0;
        end else if (ch == cpr_pkg::CH_BREAK) begin
          ev = mk_event(cpr_pkg::KIND_BREAK_RQ, cpr_pkg::CH_ACK, '0, '0, '0);
        end
      end
      RX_PAYLOAD: begin
        if (ch == cpr_pkg::CH_HASH) begin
          trk_phase = RX_SUM_HI;
        end else begin
          trk_sum = trk_sum + ch;
          if (trk_count != '1) begin
            trk_count = trk_count + 1'b1;
          end
          ev = mk_event(cpr_pkg::KIND_PAYLOAD, ch, '0, '0, '0);
        end
      end
      RX_SUM_HI: begin
        trk_first = ch;
        trk_phase = RX_SUM_LO;
      end
      default: begin
        rsum = checksum_digit(trk_first) * 13'd16 + checksum_digit(ch);
        len  = (trk_count > 16'hFFFF) ? 16'hFFFF : 16'(trk_count);
        if (rsum == {5'd0, trk_sum}) begin
          ev = mk_event(cpr_pkg::KIND_GOOD, cpr_pkg::CH_ACK, len, trk_sum, rsum);
        end else begin
          ev = mk_event(cpr_pkg::KIND_BAD, cpr_pkg::CH_NACK, len, trk_sum, rsum);
        end
        trk_phase = RX_IDLE;
      end
    endcase
    return ev;
  endfunction

  // Offers one word, after a random gap, and holds it until the block accepts it. The
  // handshake is sampled right after the edge, so in_stall still shows its pre-edge value.
  task automatic send_word(input logic [7:0] b, input bit typed = 1'b0,
                           input cpr_pkg::cpr_result_t want = NO_EVENT);
    cpr_pkg::cpr_result_t ev;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    ev = track_frame(b);
    if (typed) begin
      ev = want;
    end
    if (ev.vld) begin
      frame_events.push_back(ev);
    end
  endtask

  // Sends a framed packet with random payload. Most carry the right checksum; the rest carry
  // wrong hex digits or arbitrary characters. A truncated packet stops before the hash sign,
  // so whatever follows runs on as payload until the next hash sign closes it.
  task automatic send_frame(input int len, input bit truncate);
    logic [7:0] b;
    logic [7:0] sum;
    int         pick;
    sum = 8'h00;
    send_word(cpr_pkg::CH_DOLLAR);
    words_sent++;
    for (int i = 0; i < len; i++) begin
      do begin
        b = 8'($urandom_range(0, 255));
      end while (b == cpr_pkg::CH_HASH);
      sum = sum + b;
      send_word(b);
      words_sent++;
    end
    if (!truncate) begin
      send_word(cpr_pkg::CH_HASH);
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_word(hex_char(sum[7:4], 1'($urandom_range(0, 1))));
        send_word(hex_char(sum[3:0], 1'($urandom_range(0, 1))));
      end else if (pick < 85) begin
        send_word(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
        send_word(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
      end else begin
        send_word(8'($urandom_range(0, 255)));
        send_word(8'($urandom_range(0, 255)));
      end
      words_sent += 3;
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Result side: checks every accepted result against the oldest expectation, then decides
  // the stall for the next cycle. A pending hold-off request overrides the random stall.
  always @(posedge clk) begin
    cpr_pkg::cpr_result_t exp_ev;
    if (rst_n && out_valid && !out_stall) begin
      if (frame_events.size() == 0) begin
        $error("unexpected result: kind %0d, data_byte %0d", out_kind, out_data_byte);
        mismatches++;
      end else begin
        exp_ev = frame_events.pop_front();
        check_field("kind", 16'(exp_ev.kind), 16'(out_kind));
        check_field("data_byte", 16'(exp_ev.data_byte), 16'(out_data_byte));
        check_field("payload_length", exp_ev.payload_length, out_payload_length);
        check_field("computed_sum", 16'(exp_ev.computed_sum), 16'(out_computed_sum));
        check_field("received_sum", 16'(exp_ev.received_sum), 16'(out_received_sum));
      end
    end
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Watchdog: a run that has not finished by the limit has lost or stuck results.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int  mode;
    int  noise_words;
    bit  held;
    logic [7:0] b;
    held = 1'b0;

    // Directed probes: idle-phase filtering, an empty packet, the extreme byte values as
    // payload, bytes that are special only while idle, both hex letter cases, a hash sign and
    // a non-hex letter as checksum digits, and the largest possible received sum.
    probe_rows = '{
      '{cpr_pkg::CH_ACK,    1'b1, NO_EVENT},   // A plus sign while idle is dropped.
      '{cpr_pkg::CH_BREAK,  1'b1,
        mk_event(cpr_pkg::KIND_BREAK_RQ, cpr_pkg::CH_ACK, 16'd0, 8'd0, 13'd0)},
      '{8'h00,              1'b1, NO_EVENT},
      '{8'hFF,              1'b1, NO_EVENT},
      '{cpr_pkg::CH_DOLLAR, 1'b1, NO_EVENT},
      '{cpr_pkg::CH_HASH,   1'b1, NO_EVENT},   // Empty payload.
      '{8'h30,              1'b1, NO_EVENT},
      '{8'h30,              1'b1,
        mk_event(cpr_pkg::KIND_GOOD, cpr_pkg::CH_ACK, 16'd0, 8'd0, 13'd0)},
      '{cpr_pkg::CH_DOLLAR, 1'b1, NO_EVENT},
      '{8'hFF,              1'b1,
        mk_event(cpr_pkg::KIND_PAYLOAD, 8'hFF, 16'd0, 8'd0, 13'd0)},
      '{cpr_pkg::CH_BREAK,  1'b1,
        mk_event(cpr_pkg::KIND_PAYLOAD, cpr_pkg::CH_BREAK, 16'd0, 8'd0, 13'd0)},
      '{cpr_pkg::CH_DOLLAR, 1'b1,
        mk_event(cpr_pkg::KIND_PAYLOAD, cpr_pkg::CH_DOLLAR, 16'd0, 8'd0, 13'd0)},
      '{cpr_pkg::CH_HASH,   1'b1, NO_EVENT},
      '{8'h66,              1'b1, NO_EVENT},   // Lower case f.
      '{8'h46,              1'b0, NO_EVENT},   // Upper case F; the predictor checks the sum.
      '{cpr_pkg::CH_DOLLAR, 1'b1, NO_EVENT},
      '{8'h00,              1'b0, NO_EVENT},
      '{cpr_pkg::CH_HASH,   1'b1, NO_EVENT},
      '{cpr_pkg::CH_HASH,   1'b1, NO_EVENT},   // A hash sign taken as the first digit.
      '{8'h5A,              1'b1,
        mk_event(cpr_pkg::KIND_BAD, cpr_pkg::CH_NACK, 16'd1, 8'd0, 13'd650)},
      '{cpr_pkg::CH_DOLLAR, 1'b1, NO_EVENT},
      '{cpr_pkg::CH_HASH,   1'b1, NO_EVENT},
      '{8'hFF,              1'b1, NO_EVENT},
      '{8'hFF,              1'b1,
        mk_event(cpr_pkg::KIND_BAD, cpr_pkg::CH_NACK, 16'd0, 8'd0, 13'd4335)}
    };

    trk_phase = RX_IDLE;
    trk_sum   = '0;
    trk_count = '0;
    trk_first = '0;

    // Synchronous reset, held low at the start and then released for good.
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (probe_rows[i]) begin
      send_word(probe_rows[i].rx, probe_rows[i].typed, probe_rows[i].want);
    end

    // One long packet with no idling; it counts toward the word budget.
    send_frame(LONG_PAYLOAD, 1'b0);

    // Random part in four quarters: no idling, sender idle, receiver stalling, both. The
    // receiver quarter opens with a long hold-off while the sender keeps offering words,
    // so the block backs up and stalls its input.
    while (words_sent < RANDOM_WORDS) begin
      mode = words_sent * 4 / RANDOM_WORDS;
      case (mode)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 67;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 67;
          if (!held) begin
            hold_req = 1'b1;
            held     = 1'b1;
          end
        end
        default: begin
          send_idle_pct  = 23;
          recv_stall_pct = 23;
        end
      endcase

      // Line noise between packets; breaks are mixed in on purpose.
      if ($urandom_range(0, 99) < 25) begin
        noise_words = $urandom_range(1, 3);
        repeat (noise_words) begin
          b = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 99) < 30) begin
            b = cpr_pkg::CH_BREAK;
          end
          send_word(b);
          words_sent++;
        end
      end
      send_frame($urandom_range(0, 12), $urandom_range(0, 99) < 5);
    end
    in_valid <= 1'b0;

    // Let every predicted result arrive, then give stray results time to show up.
    while (frame_events.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
